FILE: hw/rtl/rrqs_pkg.sv
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared types and constants of the round-robin ready-queue scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

    // Fixed field widths
    localparam int ID_W      = 4;
    localparam int CTX_IN_W  = 32;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;

    // Parameter defaults
    localparam int MAX_PROCS_DEF    = 16;
    localparam int CONTEXT_BITS_DEF = 32;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NOT_ENABLED = 3'd1,
        ST_PASSTHROUGH = 3'd2,
        ST_EMPTY       = 3'd3,
        ST_FULL        = 3'd4
    } status_t;

    typedef enum logic {
        OP_MAKE_READY = 1'b0,
        OP_TICK       = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED = 1'b0,
        CFG_RUNNING = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CTX
    } state_t;

endpackage

FILE: hw/rtl/rrqs_req_if.sv
// ----------------------------------------------------------------------------
// rrqs_req_if
// Input channel: make-ready and tick items.
// ----------------------------------------------------------------------------
interface rrqs_req_if;
    import rrqs_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    logic [ID_W-1:0]     process_id;
    logic [CTX_IN_W-1:0] context_value;
    logic                current_killed;

    modport source (
        output valid,
        output operation,
        output process_id,
        output context_value,
        output current_killed,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  process_id,
        input  context_value,
        input  current_killed,
        output ready
    );
endinterface

FILE: hw/rtl/rrqs_rsp_if.sv
// ----------------------------------------------------------------------------
// rrqs_rsp_if
// Output channel: one result item per input item.
// ----------------------------------------------------------------------------
interface rrqs_rsp_if;
    import rrqs_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                current_valid;
    logic [ID_W-1:0]     running_id;
    logic [CTX_IN_W-1:0] resume_context;

    modport source (
        output valid,
        output status,
        output current_valid,
        output running_id,
        output resume_context,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  current_valid,
        input  running_id,
        input  resume_context,
        output ready
    );
endinterface

FILE: hw/rtl/round_robin_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_ready_queue_scheduler
// Each item passes S_IDLE (accept, queue read) and S_EXEC (decide, writes);
// a tick that pops also passes S_CTX (context read) before its result.
// A new item is accepted only once the last result is in the output
// register; a held result stalls the next item in S_EXEC or S_CTX.
// Reset clears control, pointers, count and running process; RAMs uncleared.
// ----------------------------------------------------------------------------
module round_robin_ready_queue_scheduler #(
    parameter int MAX_PROCS    = rrqs_pkg::MAX_PROCS_DEF,
    parameter int CONTEXT_BITS = rrqs_pkg::CONTEXT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [rrqs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrqs_pkg::CFG_DATA_W-1:0]   cfg_data,
    rrqs_req_if.sink                          req,
    rrqs_rsp_if.source                        rsp
);
    import rrqs_pkg::*;

    // Sizing. The ready queue and the context table both hold MAX_PROCS
    // entries; ids arrive as 4-bit values and are widened or trimmed to
    // the table index.
    localparam int PTR_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int IDX_EXT_W = (PTR_W > ID_W) ? PTR_W : ID_W;

    // Flow:
    //   S_IDLE  accept an item, latch it, read queue[head].
    //   S_EXEC  decide; do all table and queue writes; a tick that pops
    //           issues the context read of the popped id.
    //   S_CTX   context data back; forward the just-saved context when
    //           the popped id equals the process that was interrupted.
    // The result goes into an output register, so the next item can be
    // accepted while it waits. A state only hands off when that register
    // is free; S_EXEC holds its side effects back until then, except for a
    // popping tick, which always moves on to S_CTX.

    state_t state_reg, state_next;

    // Configuration
    logic enabled_reg;
    logic running_reg;

    // Queue and running process
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ID_W-1:0]  cur_pid_reg, cur_pid_next;
    logic             cur_present_reg, cur_present_next;
    logic             fwd_reg, fwd_next;

    // Latched item
    op_t                 op_reg;
    logic [ID_W-1:0]     pid_reg;
    logic [CTX_IN_W-1:0] ctx_reg;
    logic                killed_reg;

    // Output register
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg;
    logic                out_cur_valid_reg;
    logic [ID_W-1:0]     out_run_id_reg;
    logic [CTX_IN_W-1:0] out_resume_reg;

    // Memory ports
    logic                    q_we, q_re;
    logic [PTR_W-1:0]        q_waddr;
    logic [ID_W-1:0]         q_wdata;
    logic [ID_W-1:0]         q_rdata;
    logic                    c_we, c_re;
    logic [PTR_W-1:0]        c_waddr, c_raddr;
    logic [CONTEXT_BITS-1:0] c_wdata;
    logic [CONTEXT_BITS-1:0] c_rdata;

    // Decode
    logic                accept;
    logic                out_free;
    logic                is_tick;
    logic                pid_ok;
    logic                q_full;
    logic                q_empty;
    logic                requeue;
    logic                mr_push;
    logic                tick_live;
    logic                tick_pop;
    logic [IDX_EXT_W-1:0] pid_ext;
    logic [IDX_EXT_W-1:0] cur_ext;
    logic [IDX_EXT_W-1:0] qrd_ext;
    logic [PTR_W-1:0]    pid_idx;
    logic [PTR_W-1:0]    cur_idx;
    logic [PTR_W-1:0]    qrd_idx;
    logic [PTR_W-1:0]    head_inc;
    logic [PTR_W-1:0]    tail_inc;
    logic [CTX_IN_W-1:0] ctx_masked;

    // Result
    logic                res_load;
    status_t             res_status;
    logic                res_cur_valid;
    logic [ID_W-1:0]     res_run_id;
    logic [CTX_IN_W-1:0] res_resume;

    rrqs_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_PROCS)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    rrqs_ram #(
        .WIDTH (CONTEXT_BITS),
        .DEPTH (MAX_PROCS)
    ) u_ctx (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // ------------------------------------------------------------------------
    // Decode of the latched item against the current state
    // ------------------------------------------------------------------------
    always_comb
    begin
        accept    = req.valid && (state_reg == S_IDLE);
        out_free  = !out_valid_reg || rsp.ready;
        is_tick   = (op_reg == OP_TICK);

        pid_ext   = IDX_EXT_W'(pid_reg);
        cur_ext   = IDX_EXT_W'(cur_pid_reg);
        qrd_ext   = IDX_EXT_W'(q_rdata);
        pid_idx   = pid_ext[PTR_W-1:0];
        cur_idx   = cur_ext[PTR_W-1:0];
        qrd_idx   = qrd_ext[PTR_W-1:0];

        // ids at or past the table size are dropped like a full queue
        pid_ok    = ({1'b0, pid_ext} < (IDX_EXT_W + 1)'(MAX_PROCS));
        q_full    = (count_reg == CNT_W'(MAX_PROCS));
        q_empty   = (count_reg == '0);
        requeue   = cur_present_reg && !killed_reg;

        mr_push   = !is_tick && enabled_reg && !q_full && pid_ok;
        tick_live = is_tick && enabled_reg && running_reg;
        tick_pop  = tick_live && !q_empty;

        head_inc  = (head_reg == PTR_W'(MAX_PROCS - 1)) ? '0 : head_reg + 1'b1;
        tail_inc  = (tail_reg == PTR_W'(MAX_PROCS - 1)) ? '0 : tail_reg + 1'b1;

        // context as the table keeps it
        ctx_masked = CTX_IN_W'(CONTEXT_BITS'(ctx_reg));
    end

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (tick_pop)
                begin
                    state_next = S_CTX;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CTX:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Outputs: memory controls, state updates, result
    // ------------------------------------------------------------------------
    always_comb
    begin
        req.ready        = (state_reg == S_IDLE);

        q_re             = accept;
        q_we             = 1'b0;
        q_waddr          = tail_reg;
        q_wdata          = pid_reg;
        c_we             = 1'b0;
        c_waddr          = pid_idx;
        c_wdata          = CONTEXT_BITS'(ctx_reg);
        c_re             = 1'b0;
        c_raddr          = qrd_idx;

        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        cur_pid_next     = cur_pid_reg;
        cur_present_next = cur_present_reg;
        fwd_next         = fwd_reg;

        res_load         = 1'b0;
        res_status       = ST_OK;
        res_cur_valid    = cur_present_reg;
        res_run_id       = cur_pid_reg;
        res_resume       = '0;

        case (state_reg)
            S_IDLE:
            begin
            end
            S_EXEC:
            begin
                if (!is_tick)
                begin
                    // make ready
                    res_load = out_free;
                    if (!enabled_reg)
                    begin
                        res_status = ST_NOT_ENABLED;
                    end
                    else if (!mr_push)
                    begin
                        res_status = ST_FULL;
                    end
                    else if (out_free)
                    begin
                        c_we       = 1'b1;
                        q_we       = 1'b1;
                        tail_next  = tail_inc;
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (!enabled_reg)
                begin
                    res_load   = out_free;
                    res_status = ST_NOT_ENABLED;
                    res_resume = ctx_reg;
                end
                else if (!running_reg)
                begin
                    res_load   = out_free;
                    res_status = ST_PASSTHROUGH;
                    res_resume = ctx_reg;
                end
                else if (tick_pop)
                begin
                    // save, pop, optional requeue behind the tail
                    c_we             = cur_present_reg;
                    c_waddr          = cur_idx;
                    c_re             = 1'b1;
                    head_next        = head_inc;
                    q_wdata          = cur_pid_reg;
                    if (requeue)
                    begin
                        q_we      = 1'b1;
                        tail_next = tail_inc;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    cur_pid_next     = q_rdata;
                    cur_present_next = 1'b1;
                    // table write and read land on the same edge
                    fwd_next         = cur_present_reg && (q_rdata == cur_pid_reg);
                end
                else
                begin
                    // empty queue
                    res_load = out_free;
                    c_we     = cur_present_reg && out_free;
                    c_waddr  = cur_idx;
                    if (requeue)
                    begin
                        // same process keeps running
                        res_resume = ctx_masked;
                    end
                    else
                    begin
                        res_status    = ST_EMPTY;
                        res_cur_valid = 1'b0;
                        res_run_id    = '0;
                        res_resume    = ctx_reg;
                        if (out_free)
                        begin
                            cur_present_next = 1'b0;
                            cur_pid_next     = '0;
                        end
                    end
                end
            end
            S_CTX:
            begin
                res_load      = out_free;
                res_status    = ST_OK;
                res_cur_valid = 1'b1;
                res_run_id    = cur_pid_reg;
                res_resume    = fwd_reg ? ctx_masked : CTX_IN_W'(c_rdata);
            end
            default:
            begin
            end
        endcase

        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            enabled_reg     <= 1'b0;
            running_reg     <= 1'b0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            cur_pid_reg     <= '0;
            cur_present_reg <= 1'b0;
            fwd_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            cur_pid_reg     <= cur_pid_next;
            cur_present_reg <= cur_present_next;
            fwd_reg         <= fwd_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_write && (cfg_index == CFG_ENABLED))
            begin
                enabled_reg <= cfg_data[0];
            end
            if (cfg_write && (cfg_index == CFG_RUNNING))
            begin
                running_reg <= cfg_data[0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op_t'(req.operation);
            pid_reg    <= req.process_id;
            ctx_reg    <= req.context_value;
            killed_reg <= req.current_killed;
        end
        if (res_load)
        begin
            out_status_reg    <= res_status;
            out_cur_valid_reg <= res_cur_valid;
            out_run_id_reg    <= res_run_id;
            out_resume_reg    <= res_resume;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.current_valid  = out_cur_valid_reg;
    assign rsp.running_id     = out_run_id_reg;
    assign rsp.resume_context = out_resume_reg;
endmodule

FILE: hw/rtl/rrqs_ram.sv
// ----------------------------------------------------------------------------
// rrqs_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rrqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-before-write on an address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
